// File: src/mase_pkg.sv
`default_nettype none

package mase_pkg;

    // Field widths
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned POLE_W    = 6;
    localparam int unsigned SPEED_W   = 26;
    localparam int unsigned S_DATA_W  = 80;
    localparam int unsigned M_DATA_W  = 64;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENC_RESOLUTION = 3'd0,
        CFG_POLE_PAIRS     = 3'd1,
        CFG_ADVANCE_ANGLE  = 3'd2,
        CFG_REVERSE_DIR    = 3'd3,
        CFG_MIN_ANGLE_STEP = 3'd4
    } cfg_idx_t;

    localparam logic [ANGLE_W-1:0] RES_RESET      = 16'd16384;
    localparam logic [POLE_W-1:0]  POLES_RESET    = 6'd7;
    localparam logic [ANGLE_W-1:0] ADVANCE_RESET  = 16'd16384;
    localparam logic [ANGLE_W-1:0] MIN_STEP_RESET = 16'd10923;

    // Speed averaging ring
    localparam int unsigned AVG_DEPTH = 8;
    localparam int unsigned POS_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int unsigned SUM_W     = SPEED_W + $clog2(AVG_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Serial divider
    localparam int unsigned DIV_W = 32;
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    // count*pole_pairs, its bits fed to the divider
    localparam int unsigned PROD_W      = COUNT_W + POLE_W;
    localparam int unsigned MOD_ITERS   = PROD_W;
    localparam int unsigned FRAC_ITERS  = ANGLE_W;
    // |diff|*60e6/65536 stays below 2^25
    localparam int unsigned RATE_ITERS  = 25;
    localparam int unsigned AVG_ITERS   = SUM_W;

    // 60 s/min times 1e6 us/s
    localparam int unsigned RPM_NUM_W = 26;
    localparam logic [RPM_NUM_W-1:0] RPM_NUM = 26'd60000000;
    localparam int unsigned MULT_W = ANGLE_W + RPM_NUM_W;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MOD   = 9'b000000010,
        ST_FRAC  = 9'b000000100,
        ST_EVAL  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_RATE  = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_AVG   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// File: src/mase_div.sv
`default_nettype none

// Unsigned restoring divider, one quotient bit a cycle. The dividend is
// taken MSB first; the partial remainder may be preloaded.
module mase_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mase_pkg::div_req_t div_req,
    output mase_pkg::div_rsp_t      div_rsp
);
    import mase_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] quot_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   trial_diff;
    logic             take;

    // Shift in the next dividend bit and try the subtraction
    assign trial      = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign take       = !trial_diff[DIV_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= (div_req.iters != '0);
                done_reg <= (div_req.iters == '0);
                cnt_reg  <= div_req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg  <= div_req.rem_init;
            dvd_reg  <= div_req.dividend;
            dvs_reg  <= div_req.divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= take ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_W-2:0], take};
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quot_reg;
    assign div_rsp.rem  = rem_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == CNT_W'(1) && !div_req.start) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

`default_nettype wire

// File: src/motor_angle_speed_estimator_unit.sv
// Encoder angle and speed estimator. Each word on the s_ side carries an
// encoder count and a microsecond timestamp; one word comes out on the m_
// side for every word taken in, with the electrical angle
// ((count*pole_pairs) mod enc_resolution)*65536/enc_resolution, the drive
// phase (angle minus advance_angle, or plus it when reverse_dir is set,
// both mod 65536), the signed average electrical rpm over the last
// AVG_DEPTH speed samples (ring cleared at reset) and a flag that says
// whether this word added a sample. A sample is taken only when the wrapped
// angle change since the last sample reaches min_angle_step; the interval
// since then is clamped to 1..2^32-1 us. All divisions run through one
// bit-serial restoring divider, one quotient bit a cycle, and that divider
// sets the rate: each word runs the modulo and fraction divisions for
// the angle (skipped with enc_resolution zero), and a word that takes a
// sample also runs the rate division and the ring-sum division for the
// average. One word is worked on at a time; a finished result waits in
// the output register while the next word is taken. Configuration words
// are accepted at any time out of reset but must only be sent while no
// word is in flight.
`default_nettype none

module motor_angle_speed_estimator_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mase_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mase_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] enc_count, [79:16] time_us
    input  wire logic [mase_pkg::S_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] elec_angle, [31:16] drive_phase, [57:32] speed_rpm, [63:58] zero
    output logic [mase_pkg::M_DATA_W-1:0]        m_tdata,
    // [0] speed_updated
    output logic                                 m_tuser
);
    import mase_pkg::*;

    // Configuration registers
    logic [ANGLE_W-1:0] enc_res_reg;
    logic [POLE_W-1:0]  pole_pairs_reg;
    logic [ANGLE_W-1:0] advance_reg;
    logic               reverse_reg;
    logic [ANGLE_W-1:0] min_step_reg;

    // Control and estimator state
    state_t             state_reg;
    state_t             state_next;
    logic [ANGLE_W-1:0] last_angle_reg;
    logic [TIME_W-1:0]  last_time_reg;
    speed_t             ring_reg [AVG_DEPTH];
    logic [POS_W-1:0]   ring_pos_reg;
    sum_t               sum_reg;
    sum_t               sum_next;
    speed_t             avg_reg;
    logic               m_tvalid_reg;

    // Per-word working registers
    logic [TIME_W-1:0]  time_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] phase_reg;
    logic               neg_reg;
    logic [ANGLE_W-1:0] mag_reg;
    logic               upd_reg;
    logic [DIV_W-1:0]   interval_reg;
    logic               sum_neg_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // Datapath nets
    logic               in_accept;
    logic               out_load;
    logic [PROD_W-1:0]  prod_in;
    logic [ANGLE_W-1:0] raw_diff;
    logic               diff_neg;
    logic [ANGLE_W-1:0] diff_mag;
    logic               diff_upd;
    logic [TIME_W-1:0]  delta_t;
    logic [DIV_W-1:0]   interval_sat;
    logic [ANGLE_W-1:0] phase_calc;
    logic [MULT_W-1:0]  rate_prod;
    logic [RATE_ITERS-1:0] rate_num;
    speed_t             quot_mag;
    speed_t             sample;
    logic [SUM_W-1:0]   sum_mag;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Hold both ready lines low while in reset
    assign cfg_ready = aresetn;
    assign s_tready  = (state_reg == ST_IDLE) && aresetn;
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // count * pole_pairs straight off the input word
    assign prod_in = PROD_W'(s_tdata[COUNT_W-1:0]) * PROD_W'(pole_pairs_reg);

    // Wrapped signed angle change; exactly half a turn counts as positive
    assign raw_diff = angle_reg - last_angle_reg;
    assign diff_neg = raw_diff > HALF_TURN;
    assign diff_mag = diff_neg ? (ANGLE_W'(0) - raw_diff) : raw_diff;
    assign diff_upd = diff_mag >= min_step_reg;

    // Interval clamped to 1 .. 2^32-1 us
    assign delta_t = time_reg - last_time_reg;
    always_comb begin
        if (delta_t == '0) begin
            interval_sat = DIV_W'(1);
        end else if (delta_t[TIME_W-1:DIV_W] != '0) begin
            interval_sat = '1;
        end else begin
            interval_sat = delta_t[DIV_W-1:0];
        end
    end

    assign phase_calc = reverse_reg ? (angle_reg + advance_reg) : (angle_reg - advance_reg);

    // |diff|*60e6, then drop the 65536 of the divisor here: floor of floor
    assign rate_prod = MULT_W'(mag_reg) * MULT_W'(RPM_NUM);
    assign rate_num  = rate_prod[ANGLE_W +: RATE_ITERS];

    assign quot_mag = SPEED_W'(div_rsp.quot[RATE_ITERS-1:0]);
    assign sample   = neg_reg ? (SPEED_W'(0) - quot_mag) : quot_mag;

    // Running sum: drop the oldest sample, add the new one
    assign sum_next = sum_reg - SUM_W'(ring_reg[ring_pos_reg]) + SUM_W'(sample);
    assign sum_mag  = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;

    // Sequencer and divider requests
    always_comb begin
        state_next = state_reg;
        div_req    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (enc_res_reg != '0) begin
                        div_req.start    = 1'b1;
                        div_req.iters    = CNT_W'(MOD_ITERS);
                        div_req.dividend = DIV_W'(prod_in) << (DIV_W - PROD_W);
                        div_req.divisor  = DIV_W'(enc_res_reg);
                        state_next       = ST_MOD;
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_MOD: begin
                // Remainder seeds the fraction division
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.iters    = CNT_W'(FRAC_ITERS);
                    div_req.rem_init = div_rsp.rem;
                    div_req.divisor  = DIV_W'(enc_res_reg);
                    state_next       = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (div_rsp.done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = diff_upd ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                div_req.start    = 1'b1;
                div_req.iters    = CNT_W'(RATE_ITERS);
                div_req.dividend = DIV_W'(rate_num) << (DIV_W - RATE_ITERS);
                div_req.divisor  = interval_reg;
                state_next       = ST_RATE;
            end
            ST_RATE: begin
                if (div_rsp.done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                div_req.start    = 1'b1;
                div_req.iters    = CNT_W'(AVG_ITERS);
                div_req.dividend = DIV_W'(sum_mag) << (DIV_W - SUM_W);
                div_req.divisor  = DIV_W'(AVG_DEPTH);
                state_next       = ST_AVG;
            end
            ST_AVG: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    mase_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Control state, configuration and estimator history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_res_reg    <= RES_RESET;
            pole_pairs_reg <= POLES_RESET;
            advance_reg    <= ADVANCE_RESET;
            reverse_reg    <= 1'b0;
            min_step_reg   <= MIN_STEP_RESET;
            state_reg      <= ST_IDLE;
            last_angle_reg <= '0;
            last_time_reg  <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            ring_pos_reg   <= '0;
            sum_reg        <= '0;
            avg_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ENC_RESOLUTION: enc_res_reg    <= cfg_data;
                    CFG_POLE_PAIRS:     pole_pairs_reg <= cfg_data[POLE_W-1:0];
                    CFG_ADVANCE_ANGLE:  advance_reg    <= cfg_data;
                    CFG_REVERSE_DIR:    reverse_reg    <= cfg_data[0];
                    CFG_MIN_ANGLE_STEP: min_step_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // Commit the new sample and advance the ring
            if (state_reg == ST_RATE && div_rsp.done) begin
                ring_reg[ring_pos_reg] <= sample;
                sum_reg                <= sum_next;
                ring_pos_reg           <= (ring_pos_reg == POS_LAST) ?
                                          '0 : ring_pos_reg + POS_W'(1);
                last_angle_reg         <= angle_reg;
                last_time_reg          <= time_reg;
            end

            // Average truncates toward zero: divide the magnitude
            if (state_reg == ST_AVG && div_rsp.done) begin
                avg_reg <= sum_neg_reg ? (SPEED_W'(0) - quot_mag) : quot_mag;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Per-word payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            time_reg <= s_tdata[COUNT_W +: TIME_W];
            if (enc_res_reg == '0) begin
                angle_reg <= '0;
            end
        end
        if (state_reg == ST_FRAC && div_rsp.done) begin
            angle_reg <= div_rsp.quot[ANGLE_W-1:0];
        end
        if (state_reg == ST_EVAL) begin
            phase_reg    <= phase_calc;
            neg_reg      <= diff_neg;
            mag_reg      <= diff_mag;
            upd_reg      <= diff_upd;
            interval_reg <= interval_sat;
        end
        if (state_reg == ST_SCALE) begin
            sum_neg_reg <= sum_reg[SUM_W-1];
        end
        if (out_load) begin
            m_tdata_reg <= M_DATA_W'({avg_reg, phase_reg, angle_reg});
            m_tuser_reg <= upd_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_MOD || state_reg == ST_FRAC ||
                          state_reg == ST_RATE || state_reg == ST_AVG))
        else $error("divider finished outside a waiting state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_RATE && div_rsp.done) |=>
            ($stable(ring_pos_reg) && $stable(last_time_reg) && $stable(sum_reg)))
        else $error("speed history changed without a new sample");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not presented after completion");

endmodule

`default_nettype wire
